[hdl/joint_probability_histogram_macros.svh]
// Assertion macros used by the histogram top level.
`ifndef JOINT_PROBABILITY_HISTOGRAM_MACROS_SVH
`define JOINT_PROBABILITY_HISTOGRAM_MACROS_SVH
`ifndef SYNTHESIS
// cons must hold in the same cycle as ante
`define JPH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("histogram check failed");
// cons must hold in the cycle after ante
`define JPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("histogram check failed");
`else
`define JPH_ASSERT_IMPL(label, clk, rst, ante, cons)
`define JPH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/jph_pkg.sv]
// Types and constants of the joint probability histogram.
package jph_pkg;

   // Field widths
   localparam int VALUE_W     = 4;
   localparam int CAT_REG_W   = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int PROB_W      = 17;
   localparam int OUT_CNT_W   = 20;
   localparam int DIV_STEPS   = 17;
   localparam int DIV_STEP_W  = 5;

   localparam logic [CAT_REG_W-1:0]  CAT_RESET = 5'd16;
   localparam logic [PROB_W-1:0]     PROB_ONE  = 17'd65536;
   localparam logic [DIV_STEP_W-1:0] DIV_LAST  = 5'd16;

   // Request opcodes
   localparam logic [1:0] OP_COUNT = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_RANGE  = 2'd1;
   localparam logic [1:0] STATUS_NO_SAMPLES = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CAT_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CAT_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CAT_C = 2'd2;

   // Command kinds passed from front to back
   localparam logic [1:0] CMD_COUNT    = 2'd0;
   localparam logic [1:0] CMD_READ     = 2'd1;
   localparam logic [1:0] CMD_CLEAR    = 2'd2;
   localparam logic [1:0] CMD_READ_BAD = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic [VALUE_W-1:0] value_a;
      logic [VALUE_W-1:0] value_b;
      logic [VALUE_W-1:0] value_c;
   } req_type;

   typedef struct packed {
      logic [PROB_W-1:0]    probability;
      logic [OUT_CNT_W-1:0] cell_count;
      logic [OUT_CNT_W-1:0] total_count;
      logic [1:0]           status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [VALUE_W-1:0] value_a;
      logic [VALUE_W-1:0] value_b;
      logic [VALUE_W-1:0] value_c;
   } cmd_type;

   typedef struct packed {
      logic init_busy;
   } back_stat_type;

endpackage

[hdl/jph_queue.sv]
// Small synchronous FIFO used between front, back and result port.
module jph_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/jph_front.sv]
// Front end: category registers, range check and request classification.
module jph_front
   import jph_pkg::*;
#(
   parameter int MAX_CATEGORIES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  req_type              req_data,
   output logic                 req_full,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAT_REG_W-1:0] csr_wdata,
   input  logic                 q_full,
   output logic                 q_push,
   output cmd_type              q_data,
   input  back_stat_type        back_stat
);

   localparam logic [6:0] MAX_CAT_V = 7'(MAX_CATEGORIES);

   logic [CAT_REG_W-1:0] cat_a_ff, cat_b_ff, cat_c_ff;
   logic                 all_ok;
   logic                 keep;
   logic [1:0]           kind;

   function automatic logic in_range(input logic [VALUE_W-1:0] v,
                                     input logic [CAT_REG_W-1:0] lim);
      in_range = ({1'b0, v} < lim) && (7'(v) < MAX_CAT_V);
   endfunction

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cat_a_ff <= CAT_RESET;
         cat_b_ff <= CAT_RESET;
         cat_c_ff <= CAT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CAT_A: cat_a_ff <= csr_wdata;
            REG_CAT_B: cat_b_ff <= csr_wdata;
            REG_CAT_C: cat_c_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Range check and classification
   assign all_ok = in_range(req_data.value_a, cat_a_ff) &&
                   in_range(req_data.value_b, cat_b_ff) &&
                   in_range(req_data.value_c, cat_c_ff);

   always_comb begin
      keep = 1'b0;
      kind = CMD_COUNT;
      unique case (req_data.op)
         OP_COUNT: begin
            keep = all_ok;
            kind = CMD_COUNT;
         end
         OP_READ: begin
            keep = 1'b1;
            kind = all_ok ? CMD_READ : CMD_READ_BAD;
         end
         OP_CLEAR: begin
            keep = 1'b1;
            kind = CMD_CLEAR;
         end
         default: keep = 1'b0;
      endcase
   end

   // Hold off requests while the command queue is full or the store is wiped after reset
   assign req_full = q_full || back_stat.init_busy;
   assign q_push   = req_push && !req_full && keep;

   assign q_data = '{kind:    kind,
                     value_a: req_data.value_a,
                     value_b: req_data.value_b,
                     value_c: req_data.value_c};

endmodule

[hdl/jph_back.sv]
// Back end: count store, sample total, read divider and clearing sweep.
module jph_back
   import jph_pkg::*;
#(
   parameter int MAX_CATEGORIES = 16,
   parameter int COUNT_BITS     = 20
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       q_data,
   input  logic          q_empty,
   output logic          q_pop,
   input  logic          out_full,
   output logic          out_push,
   output rsp_type       out_data,
   output back_stat_type stat
);

   localparam int CELLS = MAX_CATEGORIES * MAX_CATEGORIES * MAX_CATEGORIES;
   localparam int IDX_W = $clog2(CELLS);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_RUN    = 3'd1;
   localparam logic [2:0] ST_CLEAR  = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [COUNT_BITS-1:0] cell_mem [CELLS];

   logic [2:0]            state_ff, state_in;
   logic [IDX_W-1:0]      sweep_ff, sweep_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic                  s1_valid_ff;
   logic [1:0]            s1_kind_ff;
   logic [IDX_W-1:0]      s1_idx_ff;
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  wr_valid_ff, wr_valid_in;
   logic [IDX_W-1:0]      wr_idx_ff, wr_idx_in;
   logic [COUNT_BITS-1:0] wr_data_ff, wr_data_in;
   logic [COUNT_BITS:0]   rem_ff, rem_in;
   logic [COUNT_BITS-1:0] den_ff, den_in;
   logic [PROB_W-1:0]     quo_ff, quo_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [COUNT_BITS-1:0] cell_hold_ff, cell_hold_in;
   rsp_type               rsp_ff, rsp_in;

   logic [IDX_W-1:0]      head_idx;
   logic [COUNT_BITS-1:0] cell_cur, cell_new, total_inc;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [COUNT_BITS-1:0] mem_wdata;
   logic                  rem_ge;
   logic [COUNT_BITS:0]   rem_sub;
   logic [PROB_W-1:0]     quo_next, prob_clip;

   // Cell address of the queue head
   assign head_idx = IDX_W'(IDX_W'(q_data.value_a) * IDX_W'(MAX_CATEGORIES * MAX_CATEGORIES)
                    + IDX_W'(q_data.value_b) * IDX_W'(MAX_CATEGORIES)
                    + IDX_W'(q_data.value_c));

   // Forward the write of the previous cycle over the stale read
   assign cell_cur  = (wr_valid_ff && wr_idx_ff == s1_idx_ff) ? wr_data_ff : rd_data_ff;
   assign cell_new  = (cell_cur == '1) ? cell_cur : cell_cur + 1'b1;
   assign total_inc = (total_ff == '1) ? total_ff : total_ff + 1'b1;

   // One restoring division step
   assign rem_ge    = (rem_ff >= {1'b0, den_ff});
   assign rem_sub   = rem_ge ? rem_ff - {1'b0, den_ff} : rem_ff;
   assign quo_next  = {quo_ff[PROB_W-2:0], rem_ge};
   assign prob_clip = (quo_next > PROB_ONE) ? PROB_ONE : quo_next;

   assign out_data       = rsp_ff;
   assign stat.init_busy = (state_ff == ST_INIT);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      total_in     = total_ff;
      wr_valid_in  = 1'b0;
      wr_idx_in    = wr_idx_ff;
      wr_data_in   = wr_data_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      cell_hold_in = cell_hold_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = s1_idx_ff;
      mem_wdata    = cell_new;
      q_pop        = 1'b0;
      out_push     = 1'b0;
      unique case (state_ff) inside
         ST_INIT, ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
            if (sweep_ff == IDX_W'(CELLS - 1)) begin
               sweep_in = '0;
               state_in = ST_RUN;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_RUN: begin
            // Counts stream; anything else stalls the head until it is done
            q_pop = !q_empty && !(s1_valid_ff && s1_kind_ff != CMD_COUNT);
            if (s1_valid_ff) begin
               unique case (s1_kind_ff)
                  CMD_COUNT: begin
                     mem_we      = 1'b1;
                     wr_valid_in = 1'b1;
                     wr_idx_in   = s1_idx_ff;
                     wr_data_in  = cell_new;
                     total_in    = total_inc;
                  end
                  CMD_READ: begin
                     if (total_ff == '0) begin
                        rsp_in = '{probability: '0, cell_count: '0,
                                   total_count: '0, status: STATUS_NO_SAMPLES};
                        state_in = ST_RESULT;
                     end else begin
                        rem_in       = {1'b0, cell_cur};
                        den_in       = total_ff;
                        quo_in       = '0;
                        step_in      = '0;
                        cell_hold_in = cell_cur;
                        state_in     = ST_DIV;
                     end
                  end
                  CMD_READ_BAD: begin
                     rsp_in = '{probability: '0, cell_count: '0,
                                total_count: OUT_CNT_W'(total_ff),
                                status: STATUS_BAD_RANGE};
                     state_in = ST_RESULT;
                  end
                  CMD_CLEAR: begin
                     total_in = '0;
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
               endcase
            end
         end
         ST_DIV: begin
            rem_in  = {rem_sub[COUNT_BITS-1:0], 1'b0};
            quo_in  = quo_next;
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               rsp_in = '{probability: prob_clip,
                          cell_count:  OUT_CNT_W'(cell_hold_ff),
                          total_count: OUT_CNT_W'(total_ff),
                          status:      STATUS_OK};
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         sweep_ff    <= '0;
         total_ff    <= '0;
         s1_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
         step_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         sweep_ff    <= sweep_in;
         total_ff    <= total_in;
         s1_valid_ff <= q_pop;
         wr_valid_ff <= wr_valid_in;
         step_ff     <= step_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_kind_ff   <= q_data.kind;
      s1_idx_ff    <= head_idx;
      wr_idx_ff    <= wr_idx_in;
      wr_data_ff   <= wr_data_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      quo_ff       <= quo_in;
      cell_hold_ff <= cell_hold_in;
      rsp_ff       <= rsp_in;
   end

   // Count store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= cell_mem[head_idx];
   end

endmodule

[hdl/joint_probability_histogram.sv]
// Top level of the joint probability histogram.
//
// Joint histogram of three categorical variables held in a MAX_CATEGORIES^3
// count memory. Count requests stream at one per cycle while no other
// request holds the back end: the memory read is registered and the
// previous cycle's write is forwarded to back-to-back requests on the same
// cell. A read request runs a 17-step restoring divider for cell/total in
// Q1.16, then hands the result to the output queue. A clear request sweeps
// all MAX_CATEGORIES^3 cells (4096 by default) of the memory, one cell per
// cycle; after reset the same sweep runs with full held high, while
// configuration writes are still taken. Out-of-range count requests and
// opcode 3 are dropped in the front end and cost no back-end time.
`include "joint_probability_histogram_macros.svh"

module joint_probability_histogram
   import jph_pkg::*;
#(
   parameter int MAX_CATEGORIES = 16,
   parameter int COUNT_BITS     = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  req_type              req_data,
   output logic                 req_full,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAT_REG_W-1:0] csr_wdata
);

   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 2;

   logic          q_push, q_full, q_pop, q_empty;
   cmd_type       q_in_data, q_out_data;
   logic          out_push, out_full;
   rsp_type       out_data;
   back_stat_type back_stat;

   jph_front #(
      .MAX_CATEGORIES(MAX_CATEGORIES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in_data),
      .back_stat(back_stat)
   );

   // Command queue between front and back
   jph_queue #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_out_data),
      .empty    (q_empty)
   );

   jph_back #(
      .MAX_CATEGORIES(MAX_CATEGORIES),
      .COUNT_BITS    (COUNT_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_data  (q_out_data),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .out_full(out_full),
      .out_push(out_push),
      .out_data(out_data),
      .stat    (back_stat)
   );

   // Result queue toward the consumer
   jph_queue #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (out_push),
      .push_data(out_data),
      .full     (out_full),
      .pop      (rsp_pop),
      .pop_data (rsp_data),
      .empty    (rsp_empty)
   );

   // Checks
   `JPH_ASSERT_IMPL(a_init_blocks_req, clock, reset, back_stat.init_busy, req_full)
   `JPH_ASSERT_IMPL(a_push_has_room, clock, reset, out_push, !out_full)
   `JPH_ASSERT_NEXT(a_push_shows_rsp, clock, reset, out_push, !rsp_empty)
   `JPH_ASSERT_IMPL(a_error_zero, clock, reset, !rsp_empty && rsp_data.status != STATUS_OK, rsp_data.probability == '0 && rsp_data.cell_count == '0)

endmodule
